### rtl/core/ecc_pkg.sv
package ecc_pkg;

  localparam int CW    = 32;
  localparam int FB    = 16;
  localparam int RW    = 31;
  localparam int NW    = FB + 2;
  localparam int DW    = CW + 1;
  localparam int PW    = 2 * DW;
  localparam int SW    = PW + 1;
  localparam int QW    = FB + 1;
  localparam int CFG_W = 2 * CW;
  localparam int IDX_W = 3;
  localparam int HALF  = 1 << (FB - 1);

  localparam int MXW   = DW + QW;
  localparam int OFF_W = MXW + 1 - FB;
  localparam int PXW   = CW + 4;
  localparam int SXW   = CW + 5;
  localparam int D2W   = 2 * RW + 2;
  localparam int SQW   = D2W / 2;
  localparam int NNW   = RW + FB + 2;
  localparam int PRW   = QW + RW;
  localparam int OXW   = PRW + 1 - FB;

  localparam logic [IDX_W-1:0] REG_EDGE_START   = 3'd0;
  localparam logic [IDX_W-1:0] REG_EDGE_END     = 3'd1;
  localparam logic [IDX_W-1:0] REG_GHOST_BEFORE = 3'd2;
  localparam logic [IDX_W-1:0] REG_GHOST_AFTER  = 3'd3;
  localparam logic [IDX_W-1:0] REG_HAS_BEFORE   = 3'd4;
  localparam logic [IDX_W-1:0] REG_HAS_AFTER    = 3'd5;

  typedef enum logic [1:0] {
    SEL_START,
    SEL_END,
    SEL_MID
  } sel_t;

  typedef struct packed {
    logic signed [CW-1:0] ax, ay, bx, by, pgx, pgy, ngx, ngy;
    logic                 has_before, has_after;
  } cfg_t;

  typedef struct packed {
    logic signed [CW-1:0] cx, cy;
    logic [RW-1:0]        r;
    sel_t                 sel;
    logic                 reject;
  } item_t;

endpackage

### rtl/core/ecc_udiv.sv
module ecc_udiv #(
  parameter int NUM_W  = 82,
  parameter int DEN_W  = 66,
  parameter int Q_W    = 17,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [Q_W-1:0]    quo,
  output logic [SIDE_W-1:0] side_out
);

  localparam int CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [CMP_W-1:0]  rem_q [Q_W];
  logic [CMP_W-1:0]  rem_nx [Q_W];
  logic [DEN_W-1:0]  den_q [Q_W];
  logic [DEN_W-1:0]  den_nx [Q_W];
  logic [Q_W-1:0]    quo_q [Q_W];
  logic [Q_W-1:0]    quo_nx [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];
  logic              vld [Q_W];

  // one quotient bit per stage, most significant first
  always_comb begin
    for (int k = 0; k < Q_W; k++) begin
      logic [CMP_W-1:0] ri;
      logic [CMP_W-1:0] t;
      logic [Q_W-1:0]   qi;
      logic [DEN_W-1:0] di;
      ri = (k == 0) ? CMP_W'(num) : rem_q[(k == 0) ? 0 : k - 1];
      qi = (k == 0) ? '0 : quo_q[(k == 0) ? 0 : k - 1];
      di = (k == 0) ? den : den_q[(k == 0) ? 0 : k - 1];
      t  = CMP_W'(di) << (Q_W - 1 - k);
      den_nx[k] = di;
      if (ri >= t) begin
        rem_nx[k] = ri - t;
        quo_nx[k] = qi | (Q_W'(1) << (Q_W - 1 - k));
      end else begin
        rem_nx[k] = ri;
        quo_nx[k] = qi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < Q_W; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int k = 1; k < Q_W; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_q[0] <= side_in;
      for (int k = 1; k < Q_W; k++) side_q[k] <= side_q[k-1];
      for (int k = 0; k < Q_W; k++) begin
        rem_q[k] <= rem_nx[k];
        den_q[k] <= den_nx[k];
        quo_q[k] <= quo_nx[k];
      end
    end
  end

  assign out_valid = vld[Q_W-1];
  assign quo       = quo_q[Q_W-1];
  assign side_out  = side_q[Q_W-1];

endmodule

### rtl/core/ecc_isqrt.sv
module ecc_isqrt #(
  parameter int IN_W   = 64,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   val,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [IN_W/2-1:0] root,
  output logic [SIDE_W-1:0] side_out
);

  localparam int STEPS = IN_W / 2;

  logic [IN_W-1:0]   val_q [STEPS];
  logic [IN_W-1:0]   res_q [STEPS];
  logic [IN_W-1:0]   val_nx [STEPS];
  logic [IN_W-1:0]   res_nx [STEPS];
  logic [SIDE_W-1:0] side_q [STEPS];
  logic              vld [STEPS];

  // digit-by-digit root, two radicand bits per stage
  always_comb begin
    for (int k = 0; k < STEPS; k++) begin
      logic [IN_W-1:0] vi;
      logic [IN_W-1:0] ri;
      logic [IN_W-1:0] bit_v;
      logic [IN_W-1:0] trial;
      vi    = (k == 0) ? val : val_q[(k == 0) ? 0 : k - 1];
      ri    = (k == 0) ? '0 : res_q[(k == 0) ? 0 : k - 1];
      bit_v = IN_W'(1) << (IN_W - 2 - 2 * k);
      trial = ri + bit_v;
      if (vi >= trial) begin
        val_nx[k] = vi - trial;
        res_nx[k] = (ri >> 1) + bit_v;
      end else begin
        val_nx[k] = vi;
        res_nx[k] = ri >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STEPS; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int k = 1; k < STEPS; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_q[0] <= side_in;
      for (int k = 1; k < STEPS; k++) side_q[k] <= side_q[k-1];
      for (int k = 0; k < STEPS; k++) begin
        val_q[k] <= val_nx[k];
        res_q[k] <= res_nx[k];
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign root      = res_q[STEPS-1][IN_W/2-1:0];
  assign side_out  = side_q[STEPS-1];

endmodule

### rtl/core/ecc_front.sv
module ecc_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  ecc_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  input  logic signed [ecc_pkg::CW-1:0] cx,
  input  logic signed [ecc_pkg::CW-1:0] cy,
  input  logic [ecc_pkg::RW-1:0]       r,
  output logic                         out_valid,
  output ecc_pkg::item_t               out_item,
  output logic [ecc_pkg::PW-1:0]       num,
  output logic [ecc_pkg::PW-1:0]       den
);

  import ecc_pkg::*;

  logic v1, v2, v3;
  item_t it1, it2, it3;
  logic signed [DW-1:0] ex, ey, wx, wy, vx, vy, pdx, pdy, ndx, ndy;
  logic signed [PW-1:0] pex, pey, pnx, pny, pbx, pby, pax, pay;
  logic signed [SW-1:0] den3, num3, dotb3, dota3;
  logic den_zero, num_neg, past_end;
  sel_t sel;
  logic reject;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_comb begin
    den_zero = (den3 == '0);
    num_neg  = num3[SW-1];
    past_end = (den3 < num3);
    reject   = 1'b0;
    if (den_zero) begin
      sel = SEL_START;
    end else if (num_neg) begin
      sel    = SEL_START;
      reject = cfg.has_before && dotb3[SW-1];
    end else if (past_end) begin
      sel    = SEL_END;
      reject = cfg.has_after && dota3[SW-1];
    end else begin
      sel = SEL_MID;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1.cx     <= cx;
      it1.cy     <= cy;
      it1.r      <= r;
      it1.sel    <= SEL_START;
      it1.reject <= 1'b0;
      ex  <= DW'(cfg.bx) - DW'(cfg.ax);
      ey  <= DW'(cfg.by) - DW'(cfg.ay);
      wx  <= DW'(cx) - DW'(cfg.ax);
      wy  <= DW'(cy) - DW'(cfg.ay);
      vx  <= DW'(cx) - DW'(cfg.bx);
      vy  <= DW'(cy) - DW'(cfg.by);
      pdx <= DW'(cfg.ax) - DW'(cfg.pgx);
      pdy <= DW'(cfg.ay) - DW'(cfg.pgy);
      ndx <= DW'(cfg.bx) - DW'(cfg.ngx);
      ndy <= DW'(cfg.by) - DW'(cfg.ngy);

      it2 <= it1;
      pex <= ex * ex;
      pey <= ey * ey;
      pnx <= wx * ex;
      pny <= wy * ey;
      pbx <= wx * pdx;
      pby <= wy * pdy;
      pax <= vx * ndx;
      pay <= vy * ndy;

      it3   <= it2;
      den3  <= SW'(pex) + SW'(pey);
      num3  <= SW'(pnx) + SW'(pny);
      dotb3 <= SW'(pbx) + SW'(pby);
      dota3 <= SW'(pax) + SW'(pay);

      out_item.cx     <= it3.cx;
      out_item.cy     <= it3.cy;
      out_item.r      <= it3.r;
      out_item.sel    <= sel;
      out_item.reject <= reject;
      num <= num3[PW-1:0];
      den <= den3[PW-1:0];
    end
  end

endmodule

### rtl/core/edge_circle_contact.sv
// edge_circle_contact: circle against one configured edge with ghost vertices
//
// input channel (in_valid/in_ready) carries one circle per transaction:
// centre_x and centre_y in Q16.16 and radius in unsigned Q15.16, in the edge frame.
// output channel (out_valid/out_ready) returns one result per transaction:
// hit, unit normal, midpoint contact point and depth; all zero on a miss.
// configuration: cfg_we writes cfg_data into register cfg_index (0 edge_start,
// 1 edge_end, 2 ghost_before, 3 ghost_after, 4 has_before, 5 has_after);
// the user must write only while no transaction is in flight, as the block does not enforce it.
// throughput: one transaction per cycle while out_ready does not stall the output.
// pipeline: input to output register runs through the 17-step projection
// divider, the 32-step square root and the 17-step normal dividers, plus the
// front products and rounding stages.
// reset: clears all configuration registers and every stage valid bit.
// stall: when a result waits with out_ready low the whole pipeline holds;
// in_ready is low only then, and nothing is dropped or repeated.
module edge_circle_contact (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ecc_pkg::IDX_W-1:0]     cfg_index,
  input  logic [ecc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [ecc_pkg::CW-1:0] centre_x,
  input  logic signed [ecc_pkg::CW-1:0] centre_y,
  input  logic [ecc_pkg::RW-1:0]        radius,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic signed [ecc_pkg::NW-1:0] normal_x,
  output logic signed [ecc_pkg::NW-1:0] normal_y,
  output logic signed [ecc_pkg::CW-1:0] contact_x,
  output logic signed [ecc_pkg::CW-1:0] contact_y,
  output logic signed [ecc_pkg::RW-1:0] depth
);

  import ecc_pkg::*;

  typedef struct packed {
    item_t                 item;
    logic signed [PXW-1:0] px, py;
    logic [RW-1:0]         mdx, mdy;
    logic                  sdx, sdy;
  } back_t;

  typedef struct packed {
    back_t         b;
    logic [SQW-1:0] d;
  } norm_t;

  function automatic logic [CW-1:0] sat_coord(input logic [SXW:0] v);
    logic [SXW-CW+1:0] top;
    top = v[SXW:CW-1];
    if (top == '0 || top == '1) sat_coord = v[CW-1:0];
    else if (v[SXW]) sat_coord = {1'b1, {(CW-1){1'b0}}};
    else sat_coord = {1'b0, {(CW-1){1'b1}}};
  endfunction

  cfg_t cfg;
  logic adv;

  logic            f_valid;
  item_t           f_item;
  logic [PW-1:0]   f_num, f_den;
  logic [PW+FB-1:0] u_num;

  logic            u_valid;
  logic [QW-1:0]   u_quo;
  item_t           u_item;

  logic signed [DW-1:0] ex_c, ey_c;
  logic            ex_neg, ey_neg;
  logic [DW-1:0]   mex, mey;

  logic            b1_v;
  item_t           b1_item;
  logic [MXW-1:0]  b1_mx, b1_my;

  logic [MXW:0]          rx, ry;
  logic signed [PXW-1:0] offx, offy, px_n, py_n;

  logic                  b2_v;
  item_t                 b2_item;
  logic signed [PXW-1:0] b2_px, b2_py;

  logic signed [PXW-1:0] dx, dy;
  logic [PXW-1:0]        mdx, mdy;
  logic                  big;

  logic            b3_v;
  back_t           b3_bk;
  logic            b4_v;
  back_t           b4_bk;
  logic [2*RW-1:0] b4_sqx, b4_sqy, b4_rr;
  logic [D2W-1:0]  d2_n;
  back_t           b5_bk_n;
  logic            b5_v;
  back_t           b5_bk;
  logic [D2W-1:0]  b5_d2;

  logic            s_valid;
  logic [SQW-1:0]  s_root;
  back_t           s_bk;

  logic            b6_v;
  logic [NNW-1:0]  b6_numx, b6_numy;
  logic [SQW:0]    b6_den;
  norm_t           b6_n;
  logic            b6_zero;

  logic            nx_valid, ny_valid;
  logic [QW-1:0]   qx, qy;
  norm_t           n_n;
  logic            n_zero;
  logic [QW-1:0]   nxm, nym;

  logic            b7_v;
  logic [QW-1:0]   b7_nxm, b7_nym;
  logic [PRW-1:0]  b7_prodx, b7_prody;
  norm_t           b7_n;

  logic [PRW:0]          oxr, oyr;
  logic signed [OXW:0]   oxs, oys;

  logic                  b8_v;
  logic signed [SXW-1:0] b8_sx, b8_sy;
  logic [QW-1:0]         b8_nxm, b8_nym;
  logic                  b8_sdx, b8_sdy, b8_reject;
  logic [SQW-1:0]        b8_d;
  logic [RW-1:0]         b8_r;

  logic [SXW:0]    sumx, sumy;
  logic [RW:0]     pen;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EDGE_START:   {cfg.ax, cfg.ay} <= cfg_data;
        REG_EDGE_END:     {cfg.bx, cfg.by} <= cfg_data;
        REG_GHOST_BEFORE: {cfg.pgx, cfg.pgy} <= cfg_data;
        REG_GHOST_AFTER:  {cfg.ngx, cfg.ngy} <= cfg_data;
        REG_HAS_BEFORE:   cfg.has_before <= cfg_data[0];
        REG_HAS_AFTER:    cfg.has_after <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ecc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .cx        (centre_x),
    .cy        (centre_y),
    .r         (radius),
    .out_valid (f_valid),
    .out_item  (f_item),
    .num       (f_num),
    .den       (f_den)
  );

  assign u_num = (f_item.sel == SEL_MID) ? {f_num, {FB{1'b0}}} : '0;

  ecc_udiv #(
    .NUM_W  (PW + FB),
    .DEN_W  (PW),
    .Q_W    (QW),
    .SIDE_W ($bits(item_t))
  ) u_proj_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .num       (u_num),
    .den       (f_den),
    .side_in   (f_item),
    .out_valid (u_valid),
    .quo       (u_quo),
    .side_out  (u_item)
  );

  assign ex_c   = DW'(cfg.bx) - DW'(cfg.ax);
  assign ey_c   = DW'(cfg.by) - DW'(cfg.ay);
  assign ex_neg = ex_c[DW-1];
  assign ey_neg = ey_c[DW-1];
  assign mex    = ex_neg ? DW'(-ex_c) : DW'(ex_c);
  assign mey    = ey_neg ? DW'(-ey_c) : DW'(ey_c);

  // closest point: edge start, edge end, or interior point rounded to nearest with ties upward
  always_comb begin
    rx   = {1'b0, b1_mx} + (MXW+1)'(HALF) - (MXW+1)'(ex_neg);
    ry   = {1'b0, b1_my} + (MXW+1)'(HALF) - (MXW+1)'(ey_neg);
    offx = ex_neg ? -$signed({1'b0, rx[MXW:FB]}) : $signed({1'b0, rx[MXW:FB]});
    offy = ey_neg ? -$signed({1'b0, ry[MXW:FB]}) : $signed({1'b0, ry[MXW:FB]});
    case (b1_item.sel)
      SEL_START: begin
        px_n = PXW'(cfg.ax);
        py_n = PXW'(cfg.ay);
      end
      SEL_END: begin
        px_n = PXW'(cfg.bx);
        py_n = PXW'(cfg.by);
      end
      SEL_MID: begin
        px_n = PXW'(cfg.ax) + offx;
        py_n = PXW'(cfg.ay) + offy;
      end
      default: begin
        px_n = PXW'(cfg.ax);
        py_n = PXW'(cfg.ay);
      end
    endcase
  end

  always_comb begin
    dx   = b2_px - PXW'(b2_item.cx);
    dy   = b2_py - PXW'(b2_item.cy);
    mdx  = dx[PXW-1] ? PXW'(-dx) : PXW'(dx);
    mdy  = dy[PXW-1] ? PXW'(-dy) : PXW'(dy);
    big  = (mdx > PXW'(b2_item.r)) || (mdy > PXW'(b2_item.r));
    d2_n = D2W'(b4_sqx) + D2W'(b4_sqy);
    b5_bk_n             = b4_bk;
    b5_bk_n.item.reject = b4_bk.item.reject | (d2_n > D2W'(b4_rr));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
      b2_v <= 1'b0;
      b3_v <= 1'b0;
      b4_v <= 1'b0;
      b5_v <= 1'b0;
    end else if (adv) begin
      b1_v <= u_valid;
      b2_v <= b1_v;
      b3_v <= b2_v;
      b4_v <= b3_v;
      b5_v <= b4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_item <= u_item;
      b1_mx   <= mex * u_quo;
      b1_my   <= mey * u_quo;

      b2_item <= b1_item;
      b2_px   <= px_n;
      b2_py   <= py_n;

      b3_bk.item.cx     <= b2_item.cx;
      b3_bk.item.cy     <= b2_item.cy;
      b3_bk.item.r      <= b2_item.r;
      b3_bk.item.sel    <= b2_item.sel;
      b3_bk.item.reject <= b2_item.reject | big;
      b3_bk.px          <= b2_px;
      b3_bk.py          <= b2_py;
      b3_bk.mdx         <= mdx[RW-1:0];
      b3_bk.mdy         <= mdy[RW-1:0];
      b3_bk.sdx         <= dx[PXW-1];
      b3_bk.sdy         <= dy[PXW-1];

      b4_bk  <= b3_bk;
      b4_sqx <= b3_bk.mdx * b3_bk.mdx;
      b4_sqy <= b3_bk.mdy * b3_bk.mdy;
      b4_rr  <= b3_bk.item.r * b3_bk.item.r;

      b5_bk <= b5_bk_n;
      b5_d2 <= d2_n;
    end
  end

  ecc_isqrt #(
    .IN_W   (D2W),
    .SIDE_W ($bits(back_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (b5_v),
    .val       (b5_d2),
    .side_in   (b5_bk),
    .out_valid (s_valid),
    .root      (s_root),
    .side_out  (s_bk)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b6_v <= 1'b0;
    end else if (adv) begin
      b6_v <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b6_numx <= (NNW'(s_bk.mdx) << (FB + 1)) + NNW'(s_root);
      b6_numy <= (NNW'(s_bk.mdy) << (FB + 1)) + NNW'(s_root);
      b6_den  <= {s_root, 1'b0};
      b6_n.b  <= s_bk;
      b6_n.d  <= s_root;
      b6_zero <= (s_root == '0);
    end
  end

  ecc_udiv #(
    .NUM_W  (NNW),
    .DEN_W  (SQW + 1),
    .Q_W    (QW),
    .SIDE_W ($bits(norm_t))
  ) u_norm_div_x (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (b6_v),
    .num       (b6_numx),
    .den       (b6_den),
    .side_in   (b6_n),
    .out_valid (nx_valid),
    .quo       (qx),
    .side_out  (n_n)
  );

  ecc_udiv #(
    .NUM_W  (NNW),
    .DEN_W  (SQW + 1),
    .Q_W    (QW),
    .SIDE_W (1)
  ) u_norm_div_y (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (b6_v),
    .num       (b6_numy),
    .den       (b6_den),
    .side_in   (b6_zero),
    .out_valid (ny_valid),
    .quo       (qy),
    .side_out  (n_zero)
  );

  assign nxm = n_zero ? '0 : qx;
  assign nym = n_zero ? '0 : qy;

  always_comb begin
    oxr  = {1'b0, b7_prodx} + (PRW+1)'(HALF);
    oyr  = {1'b0, b7_prody} + (PRW+1)'(HALF);
    oxs  = b7_n.b.sdx ? -$signed({1'b0, oxr[PRW:FB]}) : $signed({1'b0, oxr[PRW:FB]});
    oys  = b7_n.b.sdy ? -$signed({1'b0, oyr[PRW:FB]}) : $signed({1'b0, oyr[PRW:FB]});
    sumx = {b8_sx[SXW-1], b8_sx} + (SXW+1)'(1);
    sumy = {b8_sy[SXW-1], b8_sy} + (SXW+1)'(1);
    pen  = {1'b0, b8_r} - (RW+1)'(b8_d) + (RW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b7_v      <= 1'b0;
      b8_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      b7_v      <= nx_valid;
      b8_v      <= b7_v;
      out_valid <= b8_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b7_nxm   <= nxm;
      b7_nym   <= nym;
      b7_prodx <= nxm * n_n.b.item.r;
      b7_prody <= nym * n_n.b.item.r;
      b7_n     <= n_n;

      b8_sx     <= SXW'(b7_n.b.item.cx) + SXW'(oxs) + SXW'(b7_n.b.px);
      b8_sy     <= SXW'(b7_n.b.item.cy) + SXW'(oys) + SXW'(b7_n.b.py);
      b8_nxm    <= b7_nxm;
      b8_nym    <= b7_nym;
      b8_sdx    <= b7_n.b.sdx;
      b8_sdy    <= b7_n.b.sdy;
      b8_reject <= b7_n.b.item.reject;
      b8_d      <= b7_n.d;
      b8_r      <= b7_n.b.item.r;

      if (b8_reject) begin
        hit       <= 1'b0;
        normal_x  <= '0;
        normal_y  <= '0;
        contact_x <= '0;
        contact_y <= '0;
        depth     <= '0;
      end else begin
        hit       <= 1'b1;
        normal_x  <= b8_sdx ? -NW'(b8_nxm) : NW'(b8_nxm);
        normal_y  <= b8_sdy ? -NW'(b8_nym) : NW'(b8_nym);
        contact_x <= sat_coord({sumx[SXW], sumx[SXW:1]});
        contact_y <= sat_coord({sumy[SXW], sumy[SXW:1]});
        depth     <= RW'(0) - pen[RW:1];
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> normal_x == '0 && normal_y == '0 && contact_x == '0 &&
                          contact_y == '0 && depth == '0)
    else $error("miss result carries nonzero fields");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> normal_x <= 18'sd65536 && normal_x >= -18'sd65536 &&
                         normal_y <= 18'sd65536 && normal_y >= -18'sd65536)
    else $error("normal magnitude above one");

  assert property (@(posedge clk) disable iff (rst)
    nx_valid == ny_valid)
    else $error("normal divider lanes out of step");

  assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

### bench/tb_edge_circle_contact.sv
module tb_edge_circle_contact;
  import ecc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic                 hit;
    logic signed [NW-1:0] nx, ny;
    logic signed [CW-1:0] px, py;
    logic signed [RW-1:0] dep;
  } contact_t;

  typedef struct {
    logic signed [CW-1:0] cx, cy;
    logic [RW-1:0]        r;
    bit                   typed;
    contact_t             res;
  } row_t;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [IDX_W-1:0] cfg_index = REG_EDGE_START;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0, in_ready;
  logic signed [CW-1:0] centre_x = '0, centre_y = '0;
  logic [RW-1:0] radius = '0;
  logic out_valid, out_ready = 0;
  logic hit;
  logic signed [NW-1:0] normal_x, normal_y;
  logic signed [CW-1:0] contact_x, contact_y;
  logic signed [RW-1:0] depth;

  edge_circle_contact i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  logic [CFG_W-1:0] edge_reg [4];
  logic             ghost_on_before, ghost_on_after;
  contact_t         pending_contacts [$];
  bit               row_typed;
  contact_t         row_res;
  int               errors = 0;
  int               results_seen = 0;
  int               idle_cycles = 0;
  bit               burst_mode = 0;

  function automatic wide_t mag(wide_t v);
    return v < 0 ? -v : v;
  endfunction

  function automatic wide_t pt_x(logic [CFG_W-1:0] v);
    logic signed [CW-1:0] t;
    t = v[CFG_W-1:CW];
    return wide_t'(t);
  endfunction

  function automatic wide_t pt_y(logic [CFG_W-1:0] v);
    logic signed [CW-1:0] t;
    t = v[CW-1:0];
    return wide_t'(t);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic wide_t clamp_coord(wide_t v);
    if (v > 128'sd2147483647) return 128'sd2147483647;
    if (v < -128'sd2147483648) return -128'sd2147483648;
    return v;
  endfunction

  function automatic contact_t circle_contact(logic signed [CW-1:0] c_x,
                                              logic signed [CW-1:0] c_y,
                                              logic [RW-1:0] rad);
    contact_t o;
    wide_t ax, ay, bx, by, cx, cy, r, ex, ey, den, num, px, py, dx, dy, uq, gx, gy;
    wide_t d2, d, nx, ny, ox, oy, sx, sy;
    bit reject;
    o = '{default: '0};
    ax = pt_x(edge_reg[0]); ay = pt_y(edge_reg[0]);
    bx = pt_x(edge_reg[1]); by = pt_y(edge_reg[1]);
    cx = wide_t'(c_x); cy = wide_t'(c_y); r = wide_t'({1'b0, rad});
    ex = bx - ax; ey = by - ay;
    den = ex * ex + ey * ey;
    num = (cx - ax) * ex + (cy - ay) * ey;
    reject = 0;
    if (den == 0) begin
      px = ax; py = ay;
    end else if (num < 0) begin
      px = ax; py = ay;
      if (ghost_on_before) begin
        gx = pt_x(edge_reg[2]); gy = pt_y(edge_reg[2]);
        if ((cx - ax) * (ax - gx) + (cy - ay) * (ay - gy) < 0) reject = 1;
      end
    end else if (num > den) begin
      px = bx; py = by;
      if (ghost_on_after) begin
        gx = pt_x(edge_reg[3]); gy = pt_y(edge_reg[3]);
        if ((cx - bx) * (bx - gx) + (cy - by) * (by - gy) < 0) reject = 1;
      end
    end else begin
      uq = (num <<< FB) / den;
      px = ax + (ex < 0 ? -((mag(ex) * uq + HALF - 1) >>> FB) : (ex * uq + HALF) >>> FB);
      py = ay + (ey < 0 ? -((mag(ey) * uq + HALF - 1) >>> FB) : (ey * uq + HALF) >>> FB);
    end
    dx = px - cx; dy = py - cy;
    if (reject || mag(dx) > r || mag(dy) > r) return o;
    d2 = dx * dx + dy * dy;
    if (d2 > r * r) return o;
    d = wide_t'({64'd0, floor_sqrt(d2[63:0])});
    nx = 0; ny = 0;
    if (d != 0) begin
      nx = ((mag(dx) <<< (FB + 1)) + d) / (2 * d);
      ny = ((mag(dy) <<< (FB + 1)) + d) / (2 * d);
      if (dx < 0) nx = -nx;
      if (dy < 0) ny = -ny;
    end
    ox = (mag(nx) * r + HALF) >>> FB;
    oy = (mag(ny) * r + HALF) >>> FB;
    sx = cx + (nx < 0 ? -ox : ox) + px;
    sy = cy + (ny < 0 ? -oy : oy) + py;
    o.hit = 1;
    o.nx = nx[NW-1:0];
    o.ny = ny[NW-1:0];
    o.px = CW'(clamp_coord((sx + 1) >>> 1));
    o.py = CW'(clamp_coord((sy + 1) >>> 1));
    o.dep = RW'(-((r - d + 1) >>> 1));
    return o;
  endfunction

  // input transaction accepted: record what should come back
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      pending_contacts.push_back(row_typed ? row_res : circle_contact(centre_x, centre_y, radius));
  end

  always @(posedge clk) begin
    contact_t e;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_contacts.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = pending_contacts.pop_front();
        if (hit !== e.hit) begin
          $error("hit exp %0d got %0d", e.hit, hit); errors++;
        end
        if (normal_x !== e.nx) begin
          $error("normal_x exp %0d got %0d", e.nx, normal_x); errors++;
        end
        if (normal_y !== e.ny) begin
          $error("normal_y exp %0d got %0d", e.ny, normal_y); errors++;
        end
        if (contact_x !== e.px) begin
          $error("contact_x exp %0d got %0d", e.px, contact_x); errors++;
        end
        if (contact_y !== e.py) begin
          $error("contact_y exp %0d got %0d", e.py, contact_y); errors++;
        end
        if (depth !== e.dep) begin
          $error("depth exp %0d got %0d", e.dep, depth); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("[edge_circle_contact] ERROR");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    if (burst_mode) return 0;
    p = $urandom_range(0, 19);
    if (p < 12) return 0;
    if (p < 19) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random backpressure plus one long hold to fill the pipeline
  initial begin
    bit held;
    int g;
    held = 0;
    @(negedge clk);
    while (1) begin
      if (!held && results_seen > 150) begin
        held = 1;
        out_ready <= 0;
        repeat (400) @(negedge clk);
      end
      g = gap_len();
      if (g > 0) begin
        out_ready <= 0;
        repeat (g) @(negedge clk);
      end
      out_ready <= 1;
      @(negedge clk);
    end
  end

  task automatic send(logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
                      logic [RW-1:0] r, bit typed, contact_t res);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    centre_x <= cx; centre_y <= cy; radius <= r;
    row_typed <= typed; row_res <= res;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    @(negedge clk);
    in_valid <= 0;
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    if (idx < REG_HAS_BEFORE) edge_reg[idx] = v;
    else if (idx == REG_HAS_BEFORE) ghost_on_before = v[0];
    else ghost_on_after = v[0];
  endtask

  function automatic logic signed [CW-1:0] rand_coord(int sh);
    logic signed [CW-1:0] v;
    v = $urandom;
    return v >>> sh;
  endfunction

  function automatic logic [CFG_W-1:0] rand_point(int sh);
    return {rand_coord(sh), rand_coord(sh)};
  endfunction

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (pending_contacts.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_items(int n, int sh);
    logic [CFG_W-1:0] base;
    logic signed [CW-1:0] cx, cy;
    logic [RW-1:0] r;
    contact_t none;
    int k;
    none = '{default: '0};
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      base = edge_reg[$urandom_range(0, 1)];
      if (k < 2) begin
        cx = $urandom; cy = $urandom; r = RW'($urandom);
      end else begin
        cx = base[CFG_W-1:CW] + (rand_coord(sh + 1) >>> $urandom_range(0, 6));
        cy = base[CW-1:0] + (rand_coord(sh + 1) >>> $urandom_range(0, 6));
        if (k < 5) begin
          cx = edge_reg[0][CFG_W-1:CW] + ((edge_reg[1][CFG_W-1:CW] - edge_reg[0][CFG_W-1:CW])
               >>> $urandom_range(0, 3)) + (rand_coord(sh + 4));
          cy = edge_reg[0][CW-1:0] + ((edge_reg[1][CW-1:0] - edge_reg[0][CW-1:0])
               >>> $urandom_range(0, 3)) + (rand_coord(sh + 4));
        end
        r = RW'($urandom >> (sh + $urandom_range(1, 6)));
        if (r == 0) r = RW'($urandom);
      end
      send(cx, cy, r, 0, none);
    end
  endtask

  task automatic load_edge(logic [CFG_W-1:0] s, logic [CFG_W-1:0] e,
                           logic [CFG_W-1:0] gb, logic [CFG_W-1:0] ga,
                           logic [CFG_W-1:0] fb, logic [CFG_W-1:0] fa);
    write_reg(REG_EDGE_START, s);
    write_reg(REG_EDGE_END, e);
    write_reg(REG_GHOST_BEFORE, gb);
    write_reg(REG_GHOST_AFTER, ga);
    write_reg(REG_HAS_BEFORE, fb);
    write_reg(REG_HAS_AFTER, fa);
  endtask

  localparam logic signed [CW-1:0] CMAX = 32'sh7FFFFFFF;
  localparam logic signed [CW-1:0] CMIN = 32'sh80000000;
  localparam logic [RW-1:0]        RMAX = '1;
  localparam logic signed [CW-1:0] ONE  = 32'sh00010000;

  row_t directed [] = '{
    '{0, 0, 0, 1, '{1, 0, 0, 0, 0, 0}},
    '{0, 0, RMAX, 1, '{1, 0, 0, 0, 0, -31'sd1073741824}},
    '{CMAX, CMAX, 0, 1, '{0, 0, 0, 0, 0, 0}},
    '{CMIN, CMIN, RMAX, 1, '{0, 0, 0, 0, 0, 0}},
    '{ONE, 0, ONE, 0, '{default: '0}},
    '{ONE, ONE, 2 * ONE, 0, '{default: '0}},
    '{-3 * ONE, 5 * ONE, 7 * ONE, 0, '{default: '0}}
  };

  row_t edge_rows [] = '{
    '{0, ONE, 2 * ONE, 0, '{default: '0}},
    '{0, -ONE, ONE, 0, '{default: '0}},
    '{-4 * ONE, ONE, 2 * ONE, 0, '{default: '0}},
    '{4 * ONE, ONE, 2 * ONE, 0, '{default: '0}},
    '{-5 * ONE, 0, 2 * ONE, 0, '{default: '0}},
    '{5 * ONE, 0, 2 * ONE, 0, '{default: '0}},
    '{-5 * ONE, -ONE, 3 * ONE, 0, '{default: '0}},
    '{5 * ONE, ONE, 3 * ONE, 0, '{default: '0}},
    '{-6 * ONE, 2 * ONE, 2 * ONE, 0, '{default: '0}},
    '{0, 0, ONE, 0, '{default: '0}},
    '{0, 3 * ONE, ONE, 0, '{default: '0}},
    '{CMAX, CMIN, RMAX, 0, '{default: '0}},
    '{2 * ONE + 1, 100, 3 * ONE, 0, '{default: '0}}
  };

  initial begin
    foreach (edge_reg[i]) edge_reg[i] = '0;
    ghost_on_before = 0; ghost_on_after = 0;
    row_typed = 0; row_res = '{default: '0};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    foreach (directed[i])
      send(directed[i].cx, directed[i].cy, directed[i].r, directed[i].typed, directed[i].res);
    drain();

    // edge from -4 to 4 on the x axis, neighbours bending up and down
    load_edge({-4 * ONE, 32'sd0}, {4 * ONE, 32'sd0}, {-8 * ONE, -4 * ONE},
              {8 * ONE, 4 * ONE}, 64'hFFFF_0000_0000_0001, 64'h1);
    foreach (edge_rows[i])
      send(edge_rows[i].cx, edge_rows[i].cy, edge_rows[i].r, 0, edge_rows[i].res);
    random_items(250, 12);
    drain();

    // extreme corners: contact saturation and widest products
    load_edge({CMIN, CMIN}, {CMAX, CMAX}, {CMAX, CMIN}, {CMIN, CMAX}, 64'h1, 64'h1);
    send(CMIN, CMAX, RMAX, 0, row_res);
    send(CMAX, CMIN, RMAX, 0, row_res);
    send(CMAX, CMAX, RMAX, 0, row_res);
    send(CMIN, CMIN, RMAX, 0, row_res);
    random_items(200, 0);
    drain();

    // degenerate edge away from the origin
    load_edge({3 * ONE, -2 * ONE}, {3 * ONE, -2 * ONE}, '1, '0, 64'h1, 64'h1);
    random_items(200, 10);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      int sh;
      sh = $urandom_range(2, 14);
      burst_mode = (ph == 2);
      load_edge(rand_point(sh), rand_point(sh), rand_point(sh), rand_point(sh),
                {$urandom, $urandom}, {$urandom, $urandom});
      random_items(200, sh);
      drain();
    end

    if (errors == 0) $display("[edge_circle_contact] OK");
    else $display("[edge_circle_contact] ERROR");
    $finish;
  end

endmodule
